FILE: rtl/tsat_pkg.sv
`timescale 1ns / 1ps

package tsat_pkg;

    // Document limits
    localparam logic [5:0] MAX_TOKENS    = 6'd32;
    localparam logic [5:0] MAX_TERM_KEEP = 6'd63;   // characters kept per term
    localparam logic [7:0] TEXT_LIMIT    = 8'd255;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Record kinds
    localparam logic KIND_TERM_CHAR = 1'b0;
    localparam logic KIND_TOKEN_END = 1'b1;

    // Configuration register indexes
    localparam logic REG_STRIP_TAGS   = 1'b0;
    localparam logic REG_LOWERCASE_ON = 1'b1;

    typedef struct packed {
        logic       inside_tag;
        logic       inside_token;
        logic [7:0] text_offset;
        logic [7:0] token_begin;
        logic [5:0] token_count;
        logic [5:0] term_length;
    } doc_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] term_char;
        logic [4:0] position;
        logic [7:0] start_offset;
        logic [7:0] end_offset;
        logic       run_last;
    } rec_t;

    typedef struct packed {
        logic strip_tags;
        logic lowercase_on;
    } cfg_t;

endpackage

FILE: rtl/tsat_step.sv
`timescale 1ns / 1ps

module tsat_step (
    input  tsat_pkg::cfg_t       cfg,
    input  tsat_pkg::doc_state_t st,
    input  logic [7:0]           text_byte,
    input  logic                 doc_last,
    output tsat_pkg::doc_state_t st_next,
    output tsat_pkg::rec_t       rec0,
    output tsat_pkg::rec_t       rec1,
    output logic [1:0]           rec_count
);
    import tsat_pkg::*;

    rec_t       recs [2];
    logic [1:0] n;
    logic       keep;
    logic [7:0] ch;
    logic [7:0] t;
    logic [7:0] off;
    logic       alnum;

    always_comb begin
        st_next = st;
        n       = 2'd0;
        keep    = 1'b1;
        ch      = text_byte;
        off     = st.text_offset;
        t       = ch;
        alnum   = 1'b0;
        recs[0] = '0;
        recs[1] = '0;

        if (text_byte != CH_NUL && st.text_offset < TEXT_LIMIT) begin
            // Strip tags: drop '<' and what lies between the marks, and turn '>' into a space
            if (cfg.strip_tags) begin
                if (text_byte == CH_LT) begin
                    st_next.inside_tag = 1'b1;
                    keep = 1'b0;
                end else if (text_byte == CH_GT) begin
                    st_next.inside_tag = 1'b0;
                    ch = CH_SPACE;
                end else if (st.inside_tag) begin
                    keep = 1'b0;
                end
            end

            alnum = (ch >= CH_0 && ch <= CH_9) || (ch >= CH_UA && ch <= CH_UZ)
                    || (ch >= CH_LA && ch <= CH_LZ);
            t = (cfg.lowercase_on && ch >= CH_UA && ch <= CH_UZ) ? ch + CASE_GAP : ch;

            if (keep) begin
                st_next.text_offset = off + 8'd1;
                if (alnum) begin
                    // Open a token while the token budget lasts
                    if (!st.inside_token && st.token_count < MAX_TOKENS) begin
                        st_next.inside_token = 1'b1;
                        st_next.token_begin  = off;
                        st_next.term_length  = 6'd0;
                    end
                    if (st_next.inside_token && st_next.term_length < MAX_TERM_KEEP) begin
                        recs[n[0]].kind         = KIND_TERM_CHAR;
                        recs[n[0]].term_char    = t;
                        recs[n[0]].position     = st_next.token_count[4:0];
                        recs[n[0]].start_offset = st_next.token_begin;
                        recs[n[0]].end_offset   = 8'd0;
                        n = n + 2'd1;
                        st_next.term_length = st_next.term_length + 6'd1;
                    end
                end else if (st.inside_token) begin
                    // Close the token at the separator
                    recs[n[0]].kind         = KIND_TOKEN_END;
                    recs[n[0]].term_char    = 8'd0;
                    recs[n[0]].position     = st.token_count[4:0];
                    recs[n[0]].start_offset = st.token_begin;
                    recs[n[0]].end_offset   = off;
                    n = n + 2'd1;
                    st_next.token_count  = st.token_count + 6'd1;
                    st_next.inside_token = 1'b0;
                    st_next.term_length  = 6'd0;
                end
            end
        end

        // Document end: close an open token and clear the state
        if (text_byte == CH_NUL || doc_last) begin
            if (st_next.inside_token) begin
                recs[n[0]].kind         = KIND_TOKEN_END;
                recs[n[0]].term_char    = 8'd0;
                recs[n[0]].position     = st_next.token_count[4:0];
                recs[n[0]].start_offset = st_next.token_begin;
                recs[n[0]].end_offset   = st_next.text_offset;
                n = n + 2'd1;
            end
            st_next = '0;
        end

        // Mark the last record of this request
        if (n == 2'd1) begin
            recs[0].run_last = 1'b1;
        end else if (n == 2'd2) begin
            recs[1].run_last = 1'b1;
        end
    end

    assign rec0      = recs[0];
    assign rec1      = recs[1];
    assign rec_count = n;

endmodule

FILE: rtl/tsat_outbuf.sv
`timescale 1ns / 1ps

module tsat_outbuf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  logic [1:0]     push_count,
    input  tsat_pkg::rec_t push_rec0,
    input  tsat_pkg::rec_t push_rec1,
    output logic           push_ready,
    output tsat_pkg::rec_t head,
    output logic           head_valid,
    input  logic           head_ready
);
    import tsat_pkg::*;

    rec_t       q0_reg, q0_next;
    rec_t       q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop        = head_valid && head_ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q0_reg;
    // Take a new request only when the queue will be empty after this cycle
    assign push_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    // Load the records of a request, or advance the queue on a pop
    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (push) begin
            q0_next  = push_rec0;
            q1_next  = push_rec1;
            cnt_next = push_count;
        end else if (pop) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

FILE: rtl/tag_strip_alnum_tokenizer_unit.sv
`timescale 1ns / 1ps

// Byte-stream tokenizer: takes one document byte per cycle on the s_ channel,
// optionally strips angle-bracket tags, and emits one record per cycle on the
// m_ channel while m_tready is high: a term character record for each kept
// letter or digit of a token and a token end record when the token closes.
// Each byte goes through an input register, the combinational tokenizer logic
// and a two-record output queue, so a new byte is accepted every cycle while
// the output keeps pace; a byte that yields two records (a final character
// and the token end at document end) holds the input while the queue drains.
// tlast marks the last record of each byte. A zero byte or s_tlast ends the
// document and clears the tokenizer state; the configuration registers keep
// their values and should be written only while the block is idle.

module tag_strip_alnum_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_wdata,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,    // doc_last
    // Record stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] term_char, [12:8] position,
                                    // [20:13] start_offset, [28:21] end_offset
    output logic [0:0]  m_tuser,    // [0] kind
    output logic        m_tlast     // run_last
);
    import tsat_pkg::*;

    cfg_t       cfg_reg;
    doc_state_t st_reg;
    doc_state_t st_next;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       fire;
    logic       push_ready;
    rec_t       rec0;
    rec_t       rec1;
    logic [1:0] rec_count;
    rec_t       head;

    assign fire     = in_valid_reg && push_ready;
    assign s_tready = !in_valid_reg || fire;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.strip_tags   <= 1'b1;
            cfg_reg.lowercase_on <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STRIP_TAGS:   cfg_reg.strip_tags   <= cfg_wdata;
                REG_LOWERCASE_ON: cfg_reg.lowercase_on <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hold the input request until the tokenizer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Advance the document state on each processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

    tsat_step u_step (
        .cfg       (cfg_reg),
        .st        (st_reg),
        .text_byte (in_byte_reg),
        .doc_last  (in_last_reg),
        .st_next   (st_next),
        .rec0      (rec0),
        .rec1      (rec1),
        .rec_count (rec_count)
    );

    tsat_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fire),
        .push_count (rec_count),
        .push_rec0  (rec0),
        .push_rec1  (rec1),
        .push_ready (push_ready),
        .head       (head),
        .head_valid (m_tvalid),
        .head_ready (m_tready)
    );

    // Pack the head record
    assign m_tdata = {3'b000, head.end_offset, head.start_offset, head.position,
                      head.term_char};
    assign m_tuser = head.kind;
    assign m_tlast = head.run_last;

endmodule
